@@ sv/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/lmss_pkg.sv @@
package lmss_pkg;

    localparam int COL_W          = 16;
    localparam int MODULE_COLUMNS = 16;
    localparam int COL_IDX_W      = $clog2(MODULE_COLUMNS);
    localparam int MAX_MODULES    = 4;

    typedef logic [COL_W-1:0]     col_word_t;
    typedef logic [COL_IDX_W-1:0] col_idx_t;

    localparam logic REQ_REFRESH = 1'b0;
    localparam logic REQ_SCROLL  = 1'b1;

    // rows of an absent module stay dark
    localparam col_word_t ROWS_DARK = '1;

    typedef struct packed {
        logic     shift;
        col_idx_t rd_addr;
    } bank_ctrl_t;

endpackage

@@ sv/lmss_bank.sv @@
module lmss_bank
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmss_pkg::bank_ctrl_t ctrl,
    input  lmss_pkg::col_word_t  shift_in,
    output lmss_pkg::col_word_t  head,
    output lmss_pkg::col_word_t  rd_data
);
    import lmss_pkg::*;

    col_word_t cols_reg [MODULE_COLUMNS];

    // one module's columns; a scroll moves every column left by one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODULE_COLUMNS; i++)
            begin
                cols_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < MODULE_COLUMNS - 1; i++)
            begin
                cols_reg[i] <= cols_reg[i+1];
            end
            cols_reg[MODULE_COLUMNS-1] <= shift_in;
        end
    end

    assign head    = cols_reg[0];
    assign rd_data = cols_reg[ctrl.rd_addr];

endmodule

@@ sv/led_matrix_scroll_scanner.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------------------------------
// input   | in_valid  | in_stall  | req_type, column_word
// output  | out_valid | out_stall | column_index, column_select, rows_module0..3
//
// one transaction per cycle unless stalled: input register, column muxes, result register
// a scroll transaction shifts the frame and returns nothing; a refresh returns one result
// a refresh waits in the input register only while a held result blocks the result register
// reset clears the frame store and scan counter at once; no clearing pass is needed
module led_matrix_scroll_scanner
#(
    parameter int MODULE_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  lmss_pkg::col_word_t column_word,
    output logic                out_valid,
    input  logic                out_stall,
    output lmss_pkg::col_idx_t  column_index,
    output lmss_pkg::col_word_t column_select,
    output lmss_pkg::col_word_t rows_module0,
    output lmss_pkg::col_word_t rows_module1,
    output lmss_pkg::col_word_t rows_module2,
    output lmss_pkg::col_word_t rows_module3
);
    import lmss_pkg::*;

    logic      in_vld_reg, in_vld_next;
    logic      in_scroll_reg;
    col_word_t in_word_reg;
    logic      out_vld_reg, out_vld_next;
    col_idx_t  scan_reg, scan_next;
    col_idx_t  idx_reg;
    col_word_t sel_reg;
    col_word_t rows_reg [MAX_MODULES];

    logic       hold, take_in, advance, emit;
    bank_ctrl_t bank_ctrl;
    col_word_t  feed   [MODULE_COUNT];
    col_word_t  bank_q [MODULE_COUNT];
    col_word_t  rows_calc [MAX_MODULES];

    // a refresh cannot leave while the result register is held
    assign hold    = in_vld_reg && (in_scroll_reg == REQ_REFRESH) && out_vld_reg && out_stall;
    assign take_in = in_valid && !hold;
    assign advance = in_vld_reg && !hold;
    assign emit    = advance && (in_scroll_reg == REQ_REFRESH);

    assign in_vld_next  = hold ? 1'b1 : in_valid;
    assign out_vld_next = emit || (out_vld_reg && out_stall);
    assign scan_next    = emit ? scan_reg + 1'b1 : scan_reg;

    assign bank_ctrl.shift   = advance && (in_scroll_reg == REQ_SCROLL);
    assign bank_ctrl.rd_addr = scan_reg;

    assign feed[MODULE_COUNT-1] = in_word_reg;

    for (genvar m = 0; m < MODULE_COUNT; m++)
    begin : g_bank
        if (m == 0)
        begin : g_first
            lmss_bank u_bank
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (bank_ctrl),
                .shift_in (feed[m]),
                .head     (),
                .rd_data  (bank_q[m])
            );
        end
        else
        begin : g_rest
            lmss_bank u_bank
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (bank_ctrl),
                .shift_in (feed[m]),
                .head     (feed[m-1]),
                .rd_data  (bank_q[m])
            );
        end
    end

    for (genvar s = 0; s < MAX_MODULES; s++)
    begin : g_rows
        if (s < MODULE_COUNT)
        begin : g_present
            assign rows_calc[s] = ~bank_q[s];
        end
        else
        begin : g_absent
            assign rows_calc[s] = ROWS_DARK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_scroll_reg <= req_type;
            in_word_reg   <= column_word;
        end
        if (emit)
        begin
            idx_reg <= scan_reg;
            sel_reg <= col_word_t'(1) << scan_reg;
            for (int s = 0; s < MAX_MODULES; s++)
            begin
                rows_reg[s] <= rows_calc[s];
            end
        end
    end

    assign in_stall      = hold;
    assign out_valid     = out_vld_reg;
    assign column_index  = idx_reg;
    assign column_select = sel_reg;
    assign rows_module0  = rows_reg[0];
    assign rows_module1  = rows_reg[1];
    assign rows_module2  = rows_reg[2];
    assign rows_module3  = rows_reg[3];

endmodule

@@ sv/lmss_checker.sv @@
`include "assert_macros.svh"

module lmss_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input lmss_pkg::col_idx_t  column_index,
    input lmss_pkg::col_word_t column_select,
    input lmss_pkg::col_word_t rows_module0
);
    import lmss_pkg::*;

    // select must be the one-hot decode of the column index
    `ASSERT_IMPLY(a_select_decode, out_valid, column_select == (col_word_t'(1) << column_index), "column_select does not match column_index")

    // the input side only backs up behind a held result
    `ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(column_index) && $stable(rows_module0), "held result changed")

    // nothing waits on the input side while the channel is idle
    `ASSERT_IMPLY(a_stall_needs_valid, in_stall && !in_valid, out_valid, "stall without pending work")

endmodule

bind led_matrix_scroll_scanner lmss_checker u_lmss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .column_index  (column_index),
    .column_select (column_select),
    .rows_module0  (rows_module0)
);
